>>> sv/raycast_wall_texel_mapper_defines.svh
// Assertion macros for the raycast wall texel mapper checker.
`ifndef RAYCAST_WALL_TEXEL_MAPPER_DEFINES_SVH
`define RAYCAST_WALL_TEXEL_MAPPER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define RWTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RWTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/rwtm_pkg.sv
// Types and constants shared by the raycast wall texel mapper files.
package rwtm_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam int TEX_DIM_W   = 11;
    localparam int TEX_COORD_W = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_TEX_REGS = 8;
    localparam logic [TEX_DIM_W-1:0] TEX_DIM_RESET = 11'd64;

    localparam logic REG_OFS_WIDTH  = 1'b0;
    localparam logic REG_OFS_HEIGHT = 1'b1;

    localparam int DPOS_W = 24;
    localparam int PROD_W = DPOS_W + TEX_DIM_W;
    localparam int DEN_W  = 24;
    localparam int QUO_W  = TEX_COORD_W;

    typedef struct packed {
        logic               op;
        logic               hit_side;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        perp_dist;
        logic [8:0]         span_start;
        logic [9:0]         span_end;
        logic [15:0]        wall_height;
        logic [9:0]         screen_col;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  out_col;
        logic [8:0]  out_row;
        logic [1:0]  texture_sel;
        logic [9:0]  texel_col;
        logic [9:0]  texel_row;
        logic [19:0] texel_index;
        logic        last_pixel;
    } out_word_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

>>> sv/rwtm_div.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
module rwtm_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rwtm_pkg::PROD_W-1:0]  num,
    input  logic [rwtm_pkg::DEN_W-1:0]   den,
    output rwtm_pkg::div_res_t           res
);

    localparam int HI_W  = rwtm_pkg::PROD_W - rwtm_pkg::QUO_W;
    localparam int P_W   = rwtm_pkg::DEN_W + 1;
    localparam int CNT_W = $clog2(rwtm_pkg::QUO_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic                       ovf_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [P_W-1:0]             rem_reg;
    logic [rwtm_pkg::QUO_W-1:0] low_reg;
    logic [rwtm_pkg::DEN_W-1:0] den_reg;

    logic [HI_W-1:0] num_hi;
    logic [P_W-1:0]  trial;
    logic            fits;

    assign num_hi = num[rwtm_pkg::PROD_W-1:rwtm_pkg::QUO_W];
    assign trial  = {rem_reg[P_W-2:0], low_reg[rwtm_pkg::QUO_W-1]};
    assign fits   = trial >= P_W'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(rwtm_pkg::QUO_W - 1);
                rem_reg  <= P_W'(num_hi);
                low_reg  <= num[rwtm_pkg::QUO_W-1:0];
                den_reg  <= den;
                ovf_reg  <= P_W'(num_hi) >= P_W'(den);
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (trial - P_W'(den_reg)) : trial;
                low_reg <= {low_reg[rwtm_pkg::QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = low_reg;

endmodule

>>> sv/raycast_wall_texel_mapper.sv
// Top level of the raycast wall texel mapper.
//
// Input words arrive on in_valid/in_stall/in_word, pixel words leave on
// out_valid/out_stall/out_word; a word moves at an edge where valid is high
// and stall is low. Texture sizes are written on cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// A start word (op 0) selects the texture, works out the texture column and
// arms a run over the column's span if the span is not empty; it produces no
// pixel word and holds the input through its steps (multiply, fractional sum,
// scale and mirror). A step word (op 1) with a run armed holds the input
// through the row multiply, the radix-2 divider, which produces one texture
// row bit per cycle (10 bits), and the load of its pixel word into the output
// register. A step word with no run armed is absorbed and produces nothing.
// The output register holds a finished pixel word while the receiver stalls;
// the next word may be accepted and worked on meanwhile, and only the final
// load waits for the register to empty.
// Reset clears the run, empties the output register and sets every texture
// size register to 64.
module raycast_wall_texel_mapper
#(
    parameter int SCREEN_ROWS = 512,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rwtm_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rwtm_pkg::out_word_t                  out_word,
    input  logic                                 cfg_we,
    input  logic [rwtm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rwtm_pkg::TEX_DIM_W-1:0]       cfg_data
);

    localparam int FW     = 2 * FRAC_BITS;
    localparam int TP_W   = FW + rwtm_pkg::TEX_DIM_W;
    localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
    localparam int NUM_W  = rwtm_pkg::DPOS_W + 1;
    localparam int ROW_SH = 8;
    localparam int HALF_SH = 7;
    localparam logic [NUM_W-1:0] CENTRE_OFS = NUM_W'(SCREEN_ROWS * 128);
    localparam logic [10:0] ROW_LIMIT = 11'(SCREEN_ROWS);
    localparam int DW = rwtm_pkg::TEX_DIM_W;
    localparam int CW = rwtm_pkg::TEX_COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_FRAC,
        S_TCOL,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_EMIT
    } state_t;

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (v > DW'(1024))
        begin
            r = DW'(1024);
        end
        return r;
    endfunction

    function automatic logic is_pos(input logic [31:0] v);
        return (v != 32'd0) && !v[31];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [DW-1:0] tex_dim_reg [rwtm_pkg::NUM_TEX_REGS];

    logic [1:0]       cur_texture_reg;
    logic [CW-1:0]    cur_texel_col_reg;
    logic [ROW_W-1:0] cur_row_reg;
    logic [ROW_W-1:0] end_row_reg;
    logic [15:0]      cur_wh_reg;
    logic [9:0]       cur_col_reg;
    logic             active_reg;

    logic [31:0]          dir_reg;
    logic                 dir_neg_reg;
    logic [30:0]          perp_reg;
    logic [FRAC_BITS-1:0] along_lo_reg;
    logic                 mirror_reg;
    logic [DW-1:0]        w_reg;
    logic [62:0]          prod_reg;
    logic [FW-1:0]        frac_reg;

    logic [DW-1:0]                 hgt_reg;
    logic [DW-1:0]                 wid_reg;
    logic [rwtm_pkg::DPOS_W-1:0]   dpos_reg;
    logic [rwtm_pkg::PROD_W-1:0]   x_reg;
    logic [CW-1:0]                 tr_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    rwtm_pkg::out_word_t  out_word_reg;

    logic          accept;
    logic          side;
    logic [1:0]    sel;
    logic [31:0]   along_sel;
    logic [31:0]   dir_sel;
    logic [10:0]   end_clamp;
    logic [NUM_W-1:0] num;
    logic [63:0]   frac_full;
    logic [TP_W-1:0] tcol_prod;
    logic [CW-1:0] tc_raw;
    logic [DW-1:0] tc_mirror;
    logic [CW-1:0] hgt_m1;
    logic [20:0]   idx_full;
    logic [ROW_W:0] row_inc;
    logic          last;
    logic          out_free;
    rwtm_pkg::div_res_t div_res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid_next = ((state_reg == S_EMIT) && out_free) || (out_valid_reg && out_stall);

    assign side      = in_word.hit_side;
    assign sel       = side ? (is_pos(in_word.dir_y) ? 2'd0 : 2'd1)
                            : (is_pos(in_word.dir_x) ? 2'd2 : 2'd3);
    assign along_sel = side ? in_word.pos_x : in_word.pos_y;
    assign dir_sel   = side ? in_word.dir_x : in_word.dir_y;
    assign end_clamp = ({1'b0, in_word.span_end} > ROW_LIMIT) ? ROW_LIMIT
                                                              : {1'b0, in_word.span_end};

    assign num = (NUM_W'(cur_row_reg) << ROW_SH) + (NUM_W'(cur_wh_reg) << HALF_SH);

    assign frac_full = (64'(along_lo_reg) << FRAC_BITS) + 64'(prod_reg)
                     - (dir_neg_reg ? {1'b0, perp_reg, 32'd0} : 64'd0);

    assign tcol_prod = TP_W'(frac_reg) * TP_W'(w_reg);
    assign tc_raw    = tcol_prod[FW+CW-1:FW];
    assign tc_mirror = w_reg - DW'(1) - DW'(tc_raw);

    assign hgt_m1   = CW'(hgt_reg - DW'(1));
    assign idx_full = 21'(tr_reg) * 21'(wid_reg) + 21'(cur_texel_col_reg);
    assign row_inc  = (ROW_W + 1)'(cur_row_reg) + (ROW_W + 1)'(1);
    assign last     = row_inc >= (ROW_W + 1)'(end_row_reg);

    rwtm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV_GO),
        .num   (x_reg),
        .den   ({cur_wh_reg, 8'd0}),
        .res   (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_word.op == rwtm_pkg::OP_START)
                    begin
                        state_next = S_PROD;
                    end
                    else if (active_reg)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_PROD:   state_next = S_FRAC;
            S_FRAC:   state_next = S_TCOL;
            S_TCOL:   state_next = S_IDLE;
            S_MUL:    state_next = S_DIV_GO;
            S_DIV_GO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            active_reg        <= 1'b0;
            cur_texture_reg   <= '0;
            cur_texel_col_reg <= '0;
            cur_row_reg       <= '0;
            end_row_reg       <= '0;
            cur_wh_reg        <= 16'd1;
            cur_col_reg       <= '0;
            for (int i = 0; i < rwtm_pkg::NUM_TEX_REGS; i++)
            begin
                tex_dim_reg[i] <= rwtm_pkg::TEX_DIM_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_we)
            begin
                tex_dim_reg[cfg_index] <= cfg_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (in_word.op == rwtm_pkg::OP_START))
                    begin
                        dir_reg         <= dir_sel;
                        dir_neg_reg     <= dir_sel[31];
                        perp_reg        <= in_word.perp_dist;
                        along_lo_reg    <= along_sel[FRAC_BITS-1:0];
                        mirror_reg      <= side ? in_word.dir_y[31] : is_pos(in_word.dir_x);
                        w_reg           <= eff_dim(tex_dim_reg[{sel, rwtm_pkg::REG_OFS_WIDTH}]);
                        cur_texture_reg <= sel;
                        cur_row_reg     <= ROW_W'(in_word.span_start);
                        end_row_reg     <= ROW_W'(end_clamp);
                        cur_wh_reg      <= (in_word.wall_height == 16'd0) ? 16'd1
                                                                          : in_word.wall_height;
                        cur_col_reg     <= in_word.screen_col;
                        active_reg      <= 11'(in_word.span_start) < end_clamp;
                    end
                    else if (accept && active_reg)
                    begin
                        hgt_reg  <= eff_dim(tex_dim_reg[{cur_texture_reg,
                                                         rwtm_pkg::REG_OFS_HEIGHT}]);
                        wid_reg  <= eff_dim(tex_dim_reg[{cur_texture_reg,
                                                         rwtm_pkg::REG_OFS_WIDTH}]);
                        dpos_reg <= (num > CENTRE_OFS) ? rwtm_pkg::DPOS_W'(num - CENTRE_OFS)
                                                       : '0;
                    end
                end
                S_PROD:
                begin
                    prod_reg <= 63'(perp_reg) * 63'(dir_reg);
                end
                S_FRAC:
                begin
                    frac_reg <= frac_full[FW-1:0];
                end
                S_TCOL:
                begin
                    cur_texel_col_reg <= mirror_reg ? tc_mirror[CW-1:0] : tc_raw;
                end
                S_MUL:
                begin
                    x_reg <= rwtm_pkg::PROD_W'(dpos_reg) * rwtm_pkg::PROD_W'(hgt_reg);
                end
                S_DIV_GO:
                begin
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        tr_reg <= (div_res.ovf || (div_res.quo > hgt_m1)) ? hgt_m1
                                                                          : div_res.quo;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_word_reg.out_col     <= cur_col_reg;
                        out_word_reg.out_row     <= 9'(cur_row_reg);
                        out_word_reg.texture_sel <= cur_texture_reg;
                        out_word_reg.texel_col   <= cur_texel_col_reg;
                        out_word_reg.texel_row   <= tr_reg;
                        out_word_reg.texel_index <= idx_full[19:0];
                        out_word_reg.last_pixel  <= last;
                        cur_row_reg              <= ROW_W'(row_inc);
                        if (last)
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> sv/rwtm_checker.sv
// Port-level checker for the raycast wall texel mapper and its bind.
`include "raycast_wall_texel_mapper_defines.svh"

module rwtm_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input rwtm_pkg::in_word_t  in_word,
    input logic                out_valid,
    input logic                out_stall,
    input rwtm_pkg::out_word_t out_word
);

    `RWTM_ASSERT_NEXT(a_start_holds_input, in_valid && !in_stall && (in_word.op == rwtm_pkg::OP_START), in_stall, "A start word did not hold the input for its computation.")

    `RWTM_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(out_word), "A stalled output word changed or vanished.")

    `RWTM_ASSERT_NOW(a_out_after_work, $rose(out_valid), $past(in_stall), "A pixel word appeared without any computation before it.")

    `RWTM_ASSERT_NEXT(a_idle_no_load, out_valid && !out_stall && !in_stall, !out_valid, "The output register was loaded while the block was idle.")

endmodule

bind raycast_wall_texel_mapper rwtm_checker u_rwtm_checker (.*);
